>>> sv/image_orthogonal_remap_unit_assert.svh
// Assertion macros shared by the image orthogonal remap RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef IMAGE_ORTHOGONAL_REMAP_UNIT_ASSERT_SVH
`define IMAGE_ORTHOGONAL_REMAP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IORM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define IORM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/iorm_pkg.sv
// Shared types, widths and codes for the image orthogonal remap unit.
// No dependencies; the other design modules except iorm_store refer to it by scoped names.
`default_nettype none

package iorm_pkg;

    // Default build sizes.
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int PIXEL_BITS_DEF = 32;

    // Fixed field widths.
    localparam int SIZE_W      = 7;
    localparam int SIZE_MAX    = (1 << SIZE_W) - 1;
    localparam int COEF_W      = 2;
    localparam int POS_W       = 6;
    localparam int PIX_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Coefficient codes.
    localparam logic [COEF_W-1:0] COEF_ZERO = 2'b00;
    localparam logic [COEF_W-1:0] COEF_NEG1 = 2'b11;
    localparam logic [COEF_W-1:0] COEF_NEG2 = 2'b10;

    // Item kinds carried on the input tuser bit.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Reset values of the register file.
    localparam logic [SIZE_W-1:0] WIDTH_RST  = 7'd64;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 7'd64;
    localparam logic [COEF_W-1:0] COEF_ONE   = 2'b01;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_COEF_XX      = 3'd2,
        CFG_COEF_XY      = 3'd3,
        CFG_COEF_YX      = 3'd4,
        CFG_COEF_YY      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [COEF_W-1:0] xx;
        logic [COEF_W-1:0] xy;
        logic [COEF_W-1:0] yx;
        logic [COEF_W-1:0] yy;
    } t_cfg;

    // Decoded frame geometry for the current register settings.
    typedef struct packed {
        logic              ok;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic [SIZE_W-1:0] ow;
        logic [SIZE_W-1:0] oh;
        logic              x_from_col;
        logic              x_neg;
        logic              y_from_col;
        logic              y_neg;
    } t_geom;

endpackage

`default_nettype wire

>>> sv/iorm_geom.sv
// Register decode: clamps the source size, checks the matrix, derives the output size.
// Depends on iorm_pkg.
`default_nettype none

module iorm_geom #(
    parameter int MAX_WIDTH  = iorm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = iorm_pkg::MAX_HEIGHT_DEF
) (
    input  var iorm_pkg::t_cfg  i_cfg,
    output var iorm_pkg::t_geom o_geom
);

    localparam int LIM_W = (MAX_WIDTH  < iorm_pkg::SIZE_MAX) ? MAX_WIDTH  : iorm_pkg::SIZE_MAX;
    localparam int LIM_H = (MAX_HEIGHT < iorm_pkg::SIZE_MAX) ? MAX_HEIGHT : iorm_pkg::SIZE_MAX;
    localparam logic [iorm_pkg::SIZE_W-1:0] LIM_W_V = iorm_pkg::SIZE_W'(LIM_W);
    localparam logic [iorm_pkg::SIZE_W-1:0] LIM_H_V = iorm_pkg::SIZE_W'(LIM_H);
    localparam logic [iorm_pkg::SIZE_W-1:0] ONE_V   = iorm_pkg::SIZE_W'(1);

    logic [iorm_pkg::SIZE_W-1:0] w;
    logic [iorm_pkg::SIZE_W-1:0] h;
    logic nz_xx, nz_xy, nz_yx, nz_yy;
    logic any_bad;
    logic ok;

    always_comb begin
        w = (i_cfg.width == '0) ? ONE_V : ((i_cfg.width > LIM_W_V) ? LIM_W_V : i_cfg.width);
        h = (i_cfg.height == '0) ? ONE_V : ((i_cfg.height > LIM_H_V) ? LIM_H_V : i_cfg.height);

        nz_xx = (i_cfg.xx != iorm_pkg::COEF_ZERO);
        nz_xy = (i_cfg.xy != iorm_pkg::COEF_ZERO);
        nz_yx = (i_cfg.yx != iorm_pkg::COEF_ZERO);
        nz_yy = (i_cfg.yy != iorm_pkg::COEF_ZERO);

        any_bad = (i_cfg.xx == iorm_pkg::COEF_NEG2) || (i_cfg.xy == iorm_pkg::COEF_NEG2) ||
                  (i_cfg.yx == iorm_pkg::COEF_NEG2) || (i_cfg.yy == iorm_pkg::COEF_NEG2);

        // exactly one nonzero entry in each row and each column
        ok = !any_bad && (nz_xx ^ nz_xy) && (nz_yx ^ nz_yy) &&
             (nz_xx ^ nz_yx) && (nz_xy ^ nz_yy);

        o_geom.ok         = ok;
        o_geom.w          = w;
        o_geom.h          = h;
        o_geom.ow         = (ok && !nz_xx) ? h : w;
        o_geom.oh         = (ok && nz_yx) ? w : h;
        o_geom.x_from_col = nz_xx;
        o_geom.x_neg      = nz_xx ? (i_cfg.xx == iorm_pkg::COEF_NEG1)
                                  : (i_cfg.xy == iorm_pkg::COEF_NEG1);
        o_geom.y_from_col = nz_yx;
        o_geom.y_neg      = nz_yx ? (i_cfg.yx == iorm_pkg::COEF_NEG1)
                                  : (i_cfg.yy == iorm_pkg::COEF_NEG1);
    end

endmodule

`default_nettype wire

>>> sv/iorm_map.sv
// Address generation: maps a raster position or a read position to a store address.
// Depends on iorm_pkg.
`default_nettype none

module iorm_map #(
    parameter int ADDR_W = 12
) (
    input  var iorm_pkg::t_geom           i_geom,
    input  var logic                      i_mode,
    input  var logic [iorm_pkg::SIZE_W-1:0] i_x,
    input  var logic [iorm_pkg::SIZE_W-1:0] i_y,
    input  var logic [iorm_pkg::POS_W-1:0]  i_row,
    input  var logic [iorm_pkg::POS_W-1:0]  i_col,
    output var logic [ADDR_W-1:0]         o_addr,
    output var logic                      o_in_frame
);

    localparam int SW = iorm_pkg::SIZE_W;

    logic [SW-1:0]   src_x, src_y, span_x, span_y;
    logic [SW-1:0]   tx, ty;
    logic [2*SW-1:0] prod;
    logic [2*SW:0]   sum;

    always_comb begin
        src_x  = i_geom.x_from_col ? i_x : i_y;
        span_x = i_geom.x_from_col ? (i_geom.w - SW'(1)) : (i_geom.h - SW'(1));
        src_y  = i_geom.y_from_col ? i_x : i_y;
        span_y = i_geom.y_from_col ? (i_geom.w - SW'(1)) : (i_geom.h - SW'(1));

        if (i_mode == iorm_pkg::MODE_READ) begin
            tx = SW'(i_col);
            ty = SW'(i_row);
        end else begin
            // mirrored axis counts back from the far edge
            tx = i_geom.x_neg ? (span_x - src_x) : src_x;
            ty = i_geom.y_neg ? (span_y - src_y) : src_y;
        end

        prod       = ty * i_geom.ow;
        sum        = {1'b0, prod} + (2*SW+1)'(tx);
        o_addr     = ADDR_W'(sum);
        o_in_frame = i_geom.ok && (ty < i_geom.oh) && (tx < i_geom.ow);
    end

endmodule

`default_nettype wire

>>> sv/iorm_raster.sv
// Raster position counters for the load stream, with restart when the size shrinks.
// Depends on iorm_pkg.
`default_nettype none

module iorm_raster (
    input  var logic                        i_clk,
    input  var logic                        i_rst_n,
    input  var logic                        i_step,
    input  var logic [iorm_pkg::SIZE_W-1:0] i_w,
    input  var logic [iorm_pkg::SIZE_W-1:0] i_h,
    output var logic [iorm_pkg::SIZE_W-1:0] o_x,
    output var logic [iorm_pkg::SIZE_W-1:0] o_y,
    output var logic                        o_wrap
);

    localparam int SW = iorm_pkg::SIZE_W;

    logic [SW-1:0] r_x, r_y, n_x, n_y;
    logic [SW-1:0] x, y;
    logic [SW:0]   x_inc, y_inc;
    logic          restart, x_last, y_last;

    always_comb begin
        restart = (r_x >= i_w) || (r_y >= i_h);
        x       = restart ? '0 : r_x;
        y       = restart ? '0 : r_y;
        x_inc   = {1'b0, x} + (SW+1)'(1);
        y_inc   = {1'b0, y} + (SW+1)'(1);
        x_last  = (x_inc >= {1'b0, i_w});
        y_last  = (y_inc >= {1'b0, i_h});

        n_x = r_x;
        n_y = r_y;
        if (i_step) begin
            if (x_last) begin
                n_x = '0;
                n_y = y_last ? '0 : y_inc[SW-1:0];
            end else begin
                n_x = x_inc[SW-1:0];
                n_y = y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    assign o_x    = x;
    assign o_y    = y;
    assign o_wrap = x_last && y_last;

endmodule

`default_nettype wire

>>> sv/iorm_store.sv
// Frame store: single-port memory with registered read data.
// No package dependencies.
`default_nettype none

module iorm_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  var logic              i_clk,
    input  var logic              i_en,
    input  var logic              i_we,
    input  var logic [ADDR_W-1:0] i_addr,
    input  var logic [DATA_W-1:0] i_wdata,
    output var logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/image_orthogonal_remap_unit.sv
// Top level of the image orthogonal remap unit: register file, two-stage pipeline.
// Depends on iorm_pkg, iorm_geom, iorm_map, iorm_raster, iorm_store and the assert header.
//
// Use: program the source size and the 2x2 signed permutation matrix through the
// write port (i_cfg_we, i_cfg_index, i_cfg_wdata) while the pipeline is empty.
// Then stream items on s_axis: tuser 0 loads the next raster pixel into the frame
// store at its rotated/flipped position, tuser 1 reads the transformed frame at a
// destination row and column. Every transfer in gives exactly one transfer out on
// m_axis, carrying the read pixel, read_valid, output size, matrix_ok, and tlast on
// the load that finished a frame.
// Path: an input transfer is captured in the input register, then moves into the result
// register, fed by the store's registered read port, which drives m_axis.
// Throughput: one item per cycle while m_axis_tready is high, limited by the single
// store port that serves a write or a read each cycle. A read that follows a load
// sees that load's pixel.
// Reset clears the raster counters, the pipeline and the registers to their defaults
// (64x64, identity); the frame store keeps undefined contents until written.
// A result held by low m_axis_tready stalls both stages; s_axis_tready drops once full.
`default_nettype none

`include "image_orthogonal_remap_unit_assert.svh"

module image_orthogonal_remap_unit #(
    parameter int MAX_WIDTH  = iorm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = iorm_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = iorm_pkg::PIXEL_BITS_DEF
) (
    input  var logic                                i_clk,
    input  var logic                                i_rst_n,
    // register write port
    input  var logic                                i_cfg_we,
    input  var logic [iorm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  var logic [iorm_pkg::SIZE_W-1:0]         i_cfg_wdata,
    // input stream
    input  var logic                                s_axis_tvalid,
    output var logic                                s_axis_tready,
    // [31:0] pixel_in, [37:32] read_row, [43:38] read_col, [47:44] zero
    input  var logic [iorm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] mode
    input  var logic                                s_axis_tuser,
    // result stream
    output var logic                                m_axis_tvalid,
    input  var logic                                m_axis_tready,
    // [31:0] pixel_out, [32] read_valid, [39:33] out_width, [46:40] out_height,
    // [47] matrix_ok
    output var logic [iorm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // frame_done
    output var logic                                m_axis_tlast
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW     = iorm_pkg::SIZE_W;
    localparam int PW     = iorm_pkg::POS_W;
    localparam int XW     = iorm_pkg::PIX_W;

    // ---------------- register file ----------------
    iorm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= iorm_pkg::WIDTH_RST;
            r_cfg.height <= iorm_pkg::HEIGHT_RST;
            r_cfg.xx     <= iorm_pkg::COEF_ONE;
            r_cfg.xy     <= iorm_pkg::COEF_ZERO;
            r_cfg.yx     <= iorm_pkg::COEF_ZERO;
            r_cfg.yy     <= iorm_pkg::COEF_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iorm_pkg::CFG_IMAGE_WIDTH:  r_cfg.width  <= i_cfg_wdata;
                iorm_pkg::CFG_IMAGE_HEIGHT: r_cfg.height <= i_cfg_wdata;
                iorm_pkg::CFG_COEF_XX:      r_cfg.xx     <= i_cfg_wdata[iorm_pkg::COEF_W-1:0];
                iorm_pkg::CFG_COEF_XY:      r_cfg.xy     <= i_cfg_wdata[iorm_pkg::COEF_W-1:0];
                iorm_pkg::CFG_COEF_YX:      r_cfg.yx     <= i_cfg_wdata[iorm_pkg::COEF_W-1:0];
                iorm_pkg::CFG_COEF_YY:      r_cfg.yy     <= i_cfg_wdata[iorm_pkg::COEF_W-1:0];
                default: ;  // unused indexes: drop the write
            endcase
        end
    end

    iorm_pkg::t_geom geom;

    iorm_geom #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_geom (
        .i_cfg  (r_cfg),
        .o_geom (geom)
    );

    // ---------------- stage A: input register ----------------
    logic          r_a_valid;
    logic          r_a_mode;
    logic [XW-1:0] r_a_pix;
    logic [PW-1:0] r_a_row;
    logic [PW-1:0] r_a_col;

    logic adv_b;    // result register can take a new item
    logic a_free;   // input register can take a new transfer
    logic a_move;   // stage A item moves into the result register

    assign adv_b         = !m_axis_tvalid || m_axis_tready;
    assign a_free        = !r_a_valid || adv_b;
    assign a_move        = r_a_valid && adv_b;
    assign s_axis_tready = a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && s_axis_tvalid) begin
            r_a_mode <= s_axis_tuser;
            r_a_pix  <= s_axis_tdata[XW-1:0];
            r_a_row  <= s_axis_tdata[XW+PW-1:XW];
            r_a_col  <= s_axis_tdata[XW+2*PW-1:XW+PW];
        end
    end

    // ---------------- raster counters and address ----------------
    logic          is_load;
    logic          load_step;
    logic [SW-1:0] pos_x, pos_y;
    logic          wrap;
    logic [ADDR_W-1:0] addr;
    logic          in_frame;

    assign is_load   = (r_a_mode == iorm_pkg::MODE_LOAD);
    // an invalid matrix drops the load and holds the counters
    assign load_step = a_move && is_load && geom.ok;

    iorm_raster u_raster (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (load_step),
        .i_w     (geom.w),
        .i_h     (geom.h),
        .o_x     (pos_x),
        .o_y     (pos_y),
        .o_wrap  (wrap)
    );

    iorm_map #(
        .ADDR_W (ADDR_W)
    ) u_map (
        .i_geom     (geom),
        .i_mode     (r_a_mode),
        .i_x        (pos_x),
        .i_y        (pos_y),
        .i_row      (r_a_row),
        .i_col      (r_a_col),
        .o_addr     (addr),
        .o_in_frame (in_frame)
    );

    logic [PIXEL_BITS-1:0] rdata;

    iorm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (PIXEL_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (a_move),
        .i_we    (load_step),
        .i_addr  (addr),
        .i_wdata (PIXEL_BITS'(r_a_pix)),
        .o_rdata (rdata)
    );

    // ---------------- stage B: result register ----------------
    logic          r_b_valid;
    logic          r_b_rv;
    logic [SW-1:0] r_b_ow;
    logic [SW-1:0] r_b_oh;
    logic          r_b_ok;
    logic          r_b_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_rv   <= !is_load && in_frame;
            r_b_ow   <= geom.ow;
            r_b_oh   <= geom.oh;
            r_b_ok   <= geom.ok;
            r_b_done <= load_step && wrap;
        end
    end

    logic [XW-1:0] pixel_out;

    // store data is meaningful only for an in-frame read; zero otherwise
    assign pixel_out     = r_b_rv ? XW'(rdata) : '0;
    assign m_axis_tvalid = r_b_valid;
    assign m_axis_tdata  = {r_b_ok, r_b_oh, r_b_ow, r_b_rv, pixel_out};
    assign m_axis_tlast  = r_b_done;

    // ---------------- checks ----------------
    `IORM_ASSERT_IMPLY(a_store_write_ok, load_step, geom.ok && r_a_valid, "bad store write")
    `IORM_ASSERT_IMPLY(a_valid_read_ok, r_b_valid && r_b_rv, r_b_ok, "read_valid without ok")
    `IORM_ASSERT_IMPLY(a_done_is_load, r_b_valid && r_b_done, r_b_ok && !r_b_rv, "done on a read")
    `IORM_ASSERT_NEXT(a_stage_advance, a_move, r_b_valid, "item lost between stages")

endmodule

`default_nettype wire

>>> tb/sv/tb_image_orthogonal_remap_unit.sv
// Self-checking bench for image_orthogonal_remap_unit: streams raster loads and frame reads,
// predicts every result with a built-in frame remap tracker and compares field by field.
// Depends on iorm_pkg and the unit's RTL; needs no files or arguments.
module tb_image_orthogonal_remap_unit;
    import iorm_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    // Cycles without any transfer or register write before the run is declared hung.
    localparam int QUIET_LIMIT   = 3000;
    // Length of the forced receiver hold-off that backs the pipeline up.
    localparam int HOLD_CYCLES   = 64;
    // Slack after the last result: pipeline depth plus margin.
    localparam int SETTLE_CYCLES = 6;
    localparam int STORE_DEPTH   = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 42;
    localparam int READ_PCT      = 35;

    // Register indexes past the last defined register; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Handshake idling profiles.
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_pixel_item;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_out;
        logic              read_valid;
        logic [SIZE_W-1:0] out_width;
        logic [SIZE_W-1:0] out_height;
        logic              matrix_ok;
        logic              frame_done;
    } t_remap_result;

    // Tracks registers, raster counters and the frame store; queues the result each
    // accepted item must produce and matches results coming back in order.
    class remap_tracker;
        logic [SIZE_W-1:0] width_reg  = WIDTH_RST;
        logic [SIZE_W-1:0] height_reg = HEIGHT_RST;
        logic [COEF_W-1:0] c_xx = COEF_ONE;
        logic [COEF_W-1:0] c_xy = COEF_ZERO;
        logic [COEF_W-1:0] c_yx = COEF_ZERO;
        logic [COEF_W-1:0] c_yy = COEF_ONE;
        int w, h, m_xx, m_xy, m_yx, m_yy, min_x, min_y, ow, oh;
        bit ok;
        int col_cnt, row_cnt;
        logic [PIX_W-1:0] store [STORE_DEPTH];
        bit written [STORE_DEPTH];
        t_remap_result results_due [$];
        int errors, checked, loads, reads, hits, frames;

        function new();
            refresh();
        endfunction

        function void refresh();
            int ax, ay;
            if (width_reg == 0) w = 1;
            else if (width_reg > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
            else w = int'(width_reg);
            if (height_reg == 0) h = 1;
            else if (height_reg > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
            else h = int'(height_reg);
            m_xx = int'($signed(c_xx));
            m_xy = int'($signed(c_xy));
            m_yx = int'($signed(c_yx));
            m_yy = int'($signed(c_yy));
            // A signed permutation: no -2 entry, one nonzero per row and per column.
            ok = (c_xx != COEF_NEG2) && (c_xy != COEF_NEG2) &&
                 (c_yx != COEF_NEG2) && (c_yy != COEF_NEG2) &&
                 (int'(m_xx != 0) + int'(m_xy != 0) == 1) &&
                 (int'(m_yx != 0) + int'(m_yy != 0) == 1) &&
                 (int'(m_xx != 0) + int'(m_yx != 0) == 1) &&
                 (int'(m_xy != 0) + int'(m_yy != 0) == 1);
            ax = (w - 1) * m_xx + (h - 1) * m_xy;
            ay = (w - 1) * m_yx + (h - 1) * m_yy;
            min_x = (ax < 0) ? ax : 0;
            min_y = (ay < 0) ? ay : 0;
            if (ok) begin
                ow = ((ax < 0) ? -ax : ax) + 1;
                oh = ((ay < 0) ? -ay : ay) + 1;
            end else begin
                ow = w;
                oh = h;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg  = data;
                CFG_IMAGE_HEIGHT: height_reg = data;
                CFG_COEF_XX:      c_xx = data[COEF_W-1:0];
                CFG_COEF_XY:      c_xy = data[COEF_W-1:0];
                CFG_COEF_YX:      c_yx = data[COEF_W-1:0];
                CFG_COEF_YY:      c_yy = data[COEF_W-1:0];
                default: ;
            endcase
            refresh();
        endfunction

        function void take_item(t_pixel_item it);
            t_remap_result res;
            int tx, ty, idx;
            res = '0;
            res.out_width  = SIZE_W'(ow);
            res.out_height = SIZE_W'(oh);
            res.matrix_ok  = ok;
            if (it.mode == MODE_LOAD) begin
                loads++;
                // Invalid matrix: drop the load, counters hold.
                if (ok) begin
                    // Restart the frame when a size shrank below the counters.
                    if (col_cnt >= w || row_cnt >= h) begin
                        col_cnt = 0;
                        row_cnt = 0;
                    end
                    tx  = col_cnt * m_xx + row_cnt * m_xy - min_x;
                    ty  = col_cnt * m_yx + row_cnt * m_yy - min_y;
                    idx = ty * ow + tx;
                    store[idx]   = it.pixel;
                    written[idx] = 1'b1;
                    col_cnt++;
                    if (col_cnt >= w) begin
                        col_cnt = 0;
                        row_cnt++;
                        if (row_cnt >= h) begin
                            row_cnt = 0;
                            res.frame_done = 1'b1;
                            frames++;
                        end
                    end
                end
            end else begin
                reads++;
                if (ok && it.row < oh && it.col < ow) begin
                    res.pixel_out  = store[int'(it.row) * ow + int'(it.col)];
                    res.read_valid = 1'b1;
                    hits++;
                end
            end
            results_due.insert(results_due.size(), res);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 40)
                $display("mismatch on result %0d, %s: got %0h, expected %0h",
                         checked, what, got, want);
        endtask

        task match_result(logic [OUT_TDATA_W-1:0] data, logic last);
            t_remap_result want;
            checked++;
            if (results_due.size() == 0) begin
                report("result with nothing outstanding", data[31:0], '0);
                return;
            end
            want = results_due.pop_front();
            if (data[31:0] !== want.pixel_out)   report("pixel_out", data[31:0], want.pixel_out);
            if (data[32] !== want.read_valid)    report("read_valid", data[32], want.read_valid);
            if (data[39:33] !== want.out_width)  report("out_width", data[39:33], want.out_width);
            if (data[46:40] !== want.out_height) report("out_height", data[46:40], want.out_height);
            if (data[47] !== want.matrix_ok)     report("matrix_ok", data[47], want.matrix_ok);
            if (last !== want.frame_done)        report("frame_done", last, want.frame_done);
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT connections; every input holds a known value from time zero.
    // ------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = CFG_IMAGE_WIDTH;
    logic [SIZE_W-1:0]      i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [31:0] pixel_in, [37:32] read_row, [43:38] read_col, [47:44] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // [0] mode
    logic                   s_axis_tuser  = MODE_LOAD;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    // [31:0] pixel_out, [32] read_valid, [39:33] out_width, [46:40] out_height,
    // [47] matrix_ok
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // frame_done
    logic                   m_axis_tlast;

    remap_tracker remap = new();

    t_idle idle_mode   = IDLE_NONE;
    int    hold_ticket = 0;   // bumped by the sequence to request a long hold-off
    int    hold_seen   = 0;
    int    hold_left   = 0;
    int    quiet       = 0;
    int    n_settings  = 0;

    image_orthogonal_remap_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Result side: check each transfer, then pick next cycle's tready. A pending hold
    // request forces tready low for HOLD_CYCLES so the pipeline fills and stalls input.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            remap.match_result(m_axis_tdata, m_axis_tlast);
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECEIVER: m_axis_tready <= ($urandom_range(99) >= 81);
                IDLE_BOTH:     m_axis_tready <= ($urandom_range(99) >= 30);
                default:       m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Watchdog: any transfer, register write or reset cycle counts as progress.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_we || !i_rst_n) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("[image_orthogonal_remap_unit] ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Offer one item, idling first per the active profile, and hold it until the
    // transfer completes. Called right after an edge; tvalid gets one update per edge.
    task automatic push_item(t_pixel_item it);
        while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 81) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 30)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= IN_TDATA_W'({it.col, it.row, it.pixel});
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        remap.take_item(it);
    endtask

    task automatic send(logic mode, logic [PIX_W-1:0] pixel, logic [POS_W-1:0] row,
                        logic [POS_W-1:0] col);
        t_pixel_item it;
        it.mode  = mode;
        it.pixel = pixel;
        it.row   = row;
        it.col   = col;
        push_item(it);
    endtask

    // Drop tvalid and wait until every outstanding result has been transferred.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (remap.results_due.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        remap.set_reg(idx, data);
    endtask

    // Rewrite all six registers on an empty pipeline. Coefficient writes carry junk in
    // the unused upper bits; sometimes hit an unmapped index as well.
    task automatic load_settings(logic [SIZE_W-1:0] wd, logic [SIZE_W-1:0] ht,
                                 logic [COEF_W-1:0] xx, logic [COEF_W-1:0] xy,
                                 logic [COEF_W-1:0] yx, logic [COEF_W-1:0] yy);
        logic [SIZE_W-COEF_W-1:0] junk;
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_IMAGE_WIDTH, wd);
        write_reg(CFG_IMAGE_HEIGHT, ht);
        junk = (SIZE_W-COEF_W)'($urandom);
        write_reg(CFG_COEF_XX, {junk, xx});
        junk = (SIZE_W-COEF_W)'($urandom);
        write_reg(CFG_COEF_XY, {junk, xy});
        junk = (SIZE_W-COEF_W)'($urandom);
        write_reg(CFG_COEF_YX, {junk, yx});
        junk = (SIZE_W-COEF_W)'($urandom);
        write_reg(CFG_COEF_YY, {junk, yy});
        if ($urandom_range(2) == 0)
            write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, SIZE_W'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    // One random setting followed by a mix of loads and reads. Reads landing on a store
    // entry that was never written turn into loads, so only defined entries are read.
    task automatic random_phase(t_idle prof, bit long_hold, bit mid_pause);
        logic [SIZE_W-1:0] wd, ht;
        logic [COEF_W-1:0] cxx, cxy, cyx, cyy, s1, s2;
        t_pixel_item it;
        int r, c;
        case ($urandom_range(9))
            0:       wd = '0;
            1:       wd = SIZE_W'(SIZE_MAX);
            2:       wd = SIZE_W'(MAX_WIDTH_DEF);
            3:       wd = SIZE_W'($urandom_range(SIZE_MAX));
            default: wd = SIZE_W'($urandom_range(8, 1));
        endcase
        case ($urandom_range(9))
            0:       ht = '0;
            1:       ht = SIZE_W'(SIZE_MAX);
            2:       ht = SIZE_W'(MAX_HEIGHT_DEF);
            3:       ht = SIZE_W'($urandom_range(SIZE_MAX));
            default: ht = SIZE_W'($urandom_range(8, 1));
        endcase
        if ($urandom_range(3) != 0) begin
            // One of the eight rotations / flips / transposes.
            s1 = $urandom_range(1) ? COEF_NEG1 : COEF_ONE;
            s2 = $urandom_range(1) ? COEF_NEG1 : COEF_ONE;
            if ($urandom_range(1)) begin
                cxx = s1;        cxy = COEF_ZERO;
                cyx = COEF_ZERO; cyy = s2;
            end else begin
                cxx = COEF_ZERO; cxy = s1;
                cyx = s2;        cyy = COEF_ZERO;
            end
        end else begin
            // Arbitrary codes, mostly not a permutation.
            cxx = COEF_W'($urandom);
            cxy = COEF_W'($urandom);
            cyx = COEF_W'($urandom);
            cyy = COEF_W'($urandom);
        end
        load_settings(wd, ht, cxx, cxy, cyx, cyy);
        idle_mode = prof;
        if (long_hold) hold_ticket++;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            // Pause the sender until the block has returned everything.
            if (mid_pause && k == PHASE_ITEMS / 2) drain();
            it.mode = MODE_LOAD;
            it.row  = POS_W'($urandom);
            it.col  = POS_W'($urandom);
            case ($urandom_range(15))
                0:       it.pixel = '0;
                1:       it.pixel = '1;
                default: it.pixel = $urandom;
            endcase
            if ($urandom_range(99) < READ_PCT) begin
                if ($urandom_range(99) < 85) begin
                    r = $urandom_range(remap.oh - 1);
                    c = $urandom_range(remap.ow - 1);
                end else begin
                    r = $urandom_range(63);
                    c = $urandom_range(63);
                end
                if (!(remap.ok && r < remap.oh && c < remap.ow &&
                      !remap.written[r * remap.ow + c])) begin
                    it.mode = MODE_READ;
                    it.row  = POS_W'(r);
                    it.col  = POS_W'(c);
                end
            end
            push_item(it);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings (64x64 identity): pixel extremes, then read them back.
        send(MODE_LOAD, '0, 6'd63, 6'd63);
        send(MODE_LOAD, '1, 6'd0, 6'd0);
        send(MODE_LOAD, 32'hA5A5_5A5A, 6'd21, 6'd42);
        send(MODE_LOAD, 32'h5A5A_A5A5, 6'd42, 6'd21);
        send(MODE_READ, '0, 6'd0, 6'd0);
        send(MODE_READ, '1, 6'd0, 6'd3);
        send(MODE_READ, '0, 6'd0, 6'd1);

        // 3x2 source rotated by 90 degrees; the counters sit past the new width, so
        // the first load restarts the frame. Last load flags frame_done.
        load_settings(7'd3, 7'd2, COEF_ZERO, COEF_NEG1, COEF_ONE, COEF_ZERO);
        send(MODE_LOAD, 32'h0000_0001, 6'd0, 6'd0);
        send(MODE_LOAD, 32'h0000_0002, 6'd0, 6'd0);
        send(MODE_LOAD, 32'h0000_0003, 6'd0, 6'd0);
        send(MODE_LOAD, 32'h8000_0004, 6'd0, 6'd0);
        send(MODE_LOAD, 32'hFFFF_0005, 6'd0, 6'd0);
        send(MODE_LOAD, 32'h7FFF_FFFF, 6'd0, 6'd0);
        send(MODE_READ, '0, 6'd2, 6'd1);
        send(MODE_READ, '0, 6'd0, 6'd0);
        send(MODE_READ, '0, 6'd1, 6'd0);
        // Outside the output frame: zero, not valid.
        send(MODE_READ, '0, 6'd63, 6'd63);
        send(MODE_READ, '0, 6'd0, 6'd2);

        // A -2 coefficient: loads dropped, reads empty, size reported as the source.
        load_settings(7'd2, 7'd2, COEF_NEG2, COEF_ZERO, COEF_ZERO, COEF_ONE);
        send(MODE_LOAD, 32'hDEAD_BEEF, 6'd0, 6'd0);
        send(MODE_LOAD, 32'h1234_5678, 6'd0, 6'd0);
        send(MODE_READ, '0, 6'd0, 6'd0);

        // Width 0 counts as 1, height 127 clamps to 64; flip vertically.
        load_settings('0, 7'd127, COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_NEG1);
        send(MODE_LOAD, 32'hCAFE_0001, 6'd0, 6'd0);
        send(MODE_LOAD, 32'hCAFE_0002, 6'd0, 6'd0);
        send(MODE_LOAD, 32'hCAFE_0003, 6'd0, 6'd0);
        send(MODE_READ, '0, 6'd63, 6'd0);
        send(MODE_READ, '0, 6'd61, 6'd0);
        send(MODE_READ, '0, 6'd0, 6'd5);

        // Random settings, cycling through the idling profiles; two phases force a long
        // receiver hold-off, every third pauses the sender until drained.
        for (int k = 0; k < RANDOM_PHASES; k++)
            random_phase(t_idle'(k % 4), k == 0 || k == 6, k % 3 == 1);

        drain();
        idle_mode = IDLE_NONE;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d settings: %0d loads, %0d frames done, %0d reads (%0d hit)",
                 n_settings, remap.loads, remap.frames, remap.reads, remap.hits);
        $display("%0d results checked, %0d mismatches", remap.checked, remap.errors);
        if (remap.errors == 0) begin
            $display("[image_orthogonal_remap_unit] OK");
        end else begin
            $display("[image_orthogonal_remap_unit] ERROR");
        end
        $finish;
    end

endmodule
